### rtl/core/nfcfe_pkg.sv
// Package for the NFC command frame encoder.
// Holds frame constants and the sequencer step codes; depends on nothing.
package nfcfe_pkg;

  localparam logic [7:0] SpiWritePrefix = 8'h01;
  localparam logic [7:0] PreambleByte   = 8'h00;
  localparam logic [7:0] PreambleStart  = 8'hFF;
  localparam logic [7:0] TfiHost        = 8'hD4;
  localparam logic [7:0] Postamble      = 8'h00;
  localparam logic [7:0] SumSeed        = 8'hD3;  // 0xFF + 0xD4, modulo 256
  localparam logic [7:0] MinCount       = 8'd1;
  localparam logic [7:0] MaxCount       = 8'd254;
  localparam logic [7:0] BadCount       = 8'd255;

  typedef enum logic [3:0] {
    StPrefix   = 4'd0,
    StPre0     = 4'd1,
    StPre1     = 4'd2,
    StStart    = 4'd3,
    StLen      = 4'd4,
    StLcs      = 4'd5,
    StTfi      = 4'd6,
    StData     = 4'd7,
    StDcs      = 4'd8,
    StPost     = 4'd9
  } step_e;

endpackage

### rtl/core/nfcfe_in_if.sv
// Input channel of the NFC command frame encoder: one command byte per word.
// Depends on nothing.
interface nfcfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_frame;
  logic [7:0] frame_len;

  modport source (output valid, output data_byte, output first_of_frame,
                  output frame_len, input ready);
  modport sink   (input valid, input data_byte, input first_of_frame,
                  input frame_len, output ready);
endinterface

### rtl/core/nfcfe_out_if.sv
// Output channel of the NFC command frame encoder: one SPI byte per word.
// Depends on nothing.
interface nfcfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       last_in_run;
  logic       frame_done;

  modport source (output valid, output spi_byte, output last_in_run,
                  output frame_done, input ready);
  modport sink   (input valid, input spi_byte, input last_in_run,
                  input frame_done, output ready);
endinterface

### rtl/core/nfc_command_frame_encoder_top.sv
// Top level of the NFC command frame encoder.
// Depends on nfcfe_pkg, nfcfe_in_if and nfcfe_out_if.
//
// Usage: in_i carries command bytes; the word flagged first_of_frame also
// carries the byte count. out_o delivers the SPI write stream: prefix 0x01,
// preamble 00 00 FF, LEN, LCS, TFI 0xD4, the data bytes, then DCS and the
// postamble 00 (flagged frame_done) after the last counted byte.
// last_in_run marks the final output word caused by an input word.
// An input word is held in an item register; a sequencer emits one output
// word per cycle from it into the output register while that register is
// free. A first word emits prefix, preamble, LEN, LCS, TFI and its byte, a
// later data word only its byte, and the last counted byte also DCS and the
// postamble; in_i.ready is high again in the cycle the item's final word is
// loaded, so payload words stream one per cycle while out_o keeps up. A word
// arriving outside a frame without the first flag is dropped, with no output.
// When out_o.ready is low while the output register holds a word, it and the
// sequencer hold. Reset empties both registers and closes any frame.
module nfc_command_frame_encoder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  nfcfe_in_if.sink     in_i,
  nfcfe_out_if.source  out_o
);

  // Item register.
  logic                item_valid_q;
  logic [7:0]          item_data_q;
  logic                item_first_q;
  logic [7:0]          item_count_q;
  nfcfe_pkg::step_e    step_q, step_d;

  // Frame state.
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          left_q, left_d;
  logic                in_frame_q, in_frame_d;

  // Output register.
  logic                out_valid_q;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;
  logic                out_done_q, out_done_d;

  logic                out_free;
  logic                drop;
  logic                emit;
  logic                last_step;
  logic                item_done;
  logic [7:0]          clamped_count;
  logic [7:0]          len_byte;
  logic [7:0]          data_sum;
  logic [7:0]          data_left;

  assign out_free  = !out_valid_q || out_o.ready;
  assign drop      = item_valid_q && !item_first_q && !in_frame_q;
  assign emit      = item_valid_q && !drop && out_free;
  assign item_done = item_valid_q && (drop || (emit && last_step));
  assign in_i.ready = !item_valid_q || item_done;

  always_comb begin
    if (in_i.frame_len == 8'd0) begin
      clamped_count = nfcfe_pkg::MinCount;
    end else if (in_i.frame_len == nfcfe_pkg::BadCount) begin
      clamped_count = nfcfe_pkg::MaxCount;
    end else begin
      clamped_count = in_i.frame_len;
    end
  end

  assign len_byte = item_count_q + 8'd1;

  // Checksum and remaining count as they stand after the current data byte.
  always_comb begin
    if (item_first_q) begin
      data_sum  = nfcfe_pkg::SumSeed + item_data_q;
      data_left = item_count_q - 8'd1;
    end else begin
      data_sum  = sum_q + item_data_q;
      data_left = left_q - 8'd1;
    end
  end

  always_comb begin
    out_byte_d = nfcfe_pkg::Postamble;
    out_done_d = 1'b0;
    last_step  = 1'b0;
    step_d     = step_q;
    sum_d      = sum_q;
    left_d     = left_q;
    in_frame_d = in_frame_q;
    unique case (step_q)
      nfcfe_pkg::StPrefix: out_byte_d = nfcfe_pkg::SpiWritePrefix;
      nfcfe_pkg::StPre0:   out_byte_d = nfcfe_pkg::PreambleByte;
      nfcfe_pkg::StPre1:   out_byte_d = nfcfe_pkg::PreambleByte;
      nfcfe_pkg::StStart:  out_byte_d = nfcfe_pkg::PreambleStart;
      nfcfe_pkg::StLen:    out_byte_d = len_byte;
      nfcfe_pkg::StLcs:    out_byte_d = 8'd0 - len_byte;
      nfcfe_pkg::StTfi:    out_byte_d = nfcfe_pkg::TfiHost;
      nfcfe_pkg::StData: begin
        out_byte_d = item_data_q;
        sum_d      = data_sum;
        left_d     = data_left;
        in_frame_d = 1'b1;
        last_step  = (data_left != 8'd0);
      end
      nfcfe_pkg::StDcs:    out_byte_d = ~sum_q;
      nfcfe_pkg::StPost: begin
        out_byte_d = nfcfe_pkg::Postamble;
        out_done_d = 1'b1;
        last_step  = 1'b1;
        sum_d      = 8'd0;
        in_frame_d = 1'b0;
      end
      default: out_byte_d = nfcfe_pkg::Postamble;
    endcase
    if (!last_step) begin
      step_d = nfcfe_pkg::step_e'(step_q + 4'd1);
    end
    out_last_d = last_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      step_q       <= nfcfe_pkg::StPrefix;
      sum_q        <= 8'd0;
      left_q       <= 8'd0;
      in_frame_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit) begin
        sum_q      <= sum_d;
        left_q     <= left_d;
        in_frame_q <= in_frame_d;
      end
      // A newly accepted word restarts the sequencer; otherwise it advances on emit.
      if (in_i.valid && in_i.ready) begin
        item_valid_q <= 1'b1;
        step_q       <= in_i.first_of_frame ? nfcfe_pkg::StPrefix : nfcfe_pkg::StData;
      end else begin
        if (item_done) begin
          item_valid_q <= 1'b0;
        end
        if (emit) begin
          step_q <= step_d;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_data_q  <= in_i.data_byte;
      item_first_q <= in_i.first_of_frame;
      item_count_q <= clamped_count;
    end
    if (emit) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
      out_done_q <= out_done_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.spi_byte    = out_byte_q;
  assign out_o.last_in_run = out_last_q;
  assign out_o.frame_done  = out_done_q;

endmodule

### dv/tb_nfc_command_frame_encoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for nfc_command_frame_encoder_top: command bytes go in, and
// every SPI word that comes out is checked against a predicted frame stream.
// Depends on nfcfe_pkg, nfcfe_in_if, nfcfe_out_if and the encoder top level.
module tb_nfc_command_frame_encoder_top;

  localparam int QuietLimit   = 2000;
  localparam int LongHoldLen  = 300;
  localparam int RandomTarget = 460;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last_in_run;
    logic       frame_done;
  } spi_word_t;

  typedef enum int {RxFree, RxCoin, RxSparse, RxMostly} rx_mode_e;

  // Tracks the frame state and queues the SPI words that each command word must produce.
  class spi_stream_checker;
    spi_word_t  pending[$];
    logic [7:0] csum_acc;
    logic [7:0] bytes_owed;
    bit         frame_open;
    int         errors;

    function new();
      csum_acc   = 8'd0;
      bytes_owed = 8'd0;
      frame_open = 1'b0;
      errors     = 0;
    endfunction

    function void push_word(logic [7:0] b, bit last, bit done);
      spi_word_t w;
      w.spi_byte    = b;
      w.last_in_run = last;
      w.frame_done  = done;
      pending.push_back(w);
    endfunction

    function void push_payload(logic [7:0] b);
      bit closes;
      bytes_owed = bytes_owed - 8'd1;
      closes     = (bytes_owed == 8'd0);
      push_word(b, !closes, 1'b0);
      csum_acc = csum_acc + b;
      if (closes) begin
        push_word(~csum_acc, 1'b0, 1'b0);
        push_word(nfcfe_pkg::Postamble, 1'b1, 1'b1);
        frame_open = 1'b0;
        csum_acc   = 8'd0;
      end
    endfunction

    // Returns 1 when the word is part of a frame, 0 when the block drops it.
    function bit take_command_word(logic [7:0] data, logic first, logic [7:0] count);
      logic [7:0] n;
      logic [7:0] len;
      if (first) begin
        n = count;
        if (n == 8'd0) n = nfcfe_pkg::MinCount;
        if (n == nfcfe_pkg::BadCount) n = nfcfe_pkg::MaxCount;
        len = n + 8'd1;
        push_word(nfcfe_pkg::SpiWritePrefix, 1'b0, 1'b0);
        push_word(nfcfe_pkg::PreambleByte, 1'b0, 1'b0);
        push_word(nfcfe_pkg::PreambleByte, 1'b0, 1'b0);
        push_word(nfcfe_pkg::PreambleStart, 1'b0, 1'b0);
        push_word(len, 1'b0, 1'b0);
        push_word(8'h00 - len, 1'b0, 1'b0);
        push_word(nfcfe_pkg::TfiHost, 1'b0, 1'b0);
        csum_acc   = nfcfe_pkg::PreambleStart + nfcfe_pkg::TfiHost;
        bytes_owed = n;
        frame_open = 1'b1;
        push_payload(data);
        return 1'b1;
      end
      if (frame_open) begin
        push_payload(data);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_spi_word(spi_word_t got);
      spi_word_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, got byte %02h last %0b done %0b",
                 $time, got.spi_byte, got.last_in_run, got.frame_done);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.spi_byte !== exp.spi_byte) begin
        $display("%0t: spi_byte expected %02h got %02h", $time, exp.spi_byte, got.spi_byte);
        errors++;
      end
      if (got.last_in_run !== exp.last_in_run) begin
        $display("%0t: last_in_run expected %0b got %0b", $time, exp.last_in_run,
                 got.last_in_run);
        errors++;
      end
      if (got.frame_done !== exp.frame_done) begin
        $display("%0t: frame_done expected %0b got %0b", $time, exp.frame_done,
                 got.frame_done);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nfcfe_in_if  cmd_if();
  nfcfe_out_if spi_if();

  nfc_command_frame_encoder_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_if),
    .out_o (spi_if)
  );

  spi_stream_checker tracker;
  int  burst_left;
  int  framed_words;
  int  quiet_cycles;
  bit  long_hold_req;

  always #1 clk = ~clk;

  // Output monitor; also feeds the stall watchdog.
  always @(posedge clk) begin
    spi_word_t got;
    if (rst_n) begin
      if (spi_if.valid && spi_if.ready) begin
        got.spi_byte    = spi_if.spi_byte;
        got.last_in_run = spi_if.last_in_run;
        got.frame_done  = spi_if.frame_done;
        tracker.check_spi_word(got);
      end
      if ((spi_if.valid && spi_if.ready) || (cmd_if.valid && cmd_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: switches at random among free, coin-flip, sparse and mostly-ready stall patterns, and once holds off long
  // enough for the encoder to back up into its input.
  initial begin
    rx_mode_e rx_mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    bit       hold_done;
    rx_mode   = RxFree;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    hold_done = 1'b0;
    spi_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LongHoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        spi_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (rx_mode)
          RxFree:   spi_if.ready <= 1'b1;
          RxCoin:   spi_if.ready <= 1'($urandom_range(0, 1));
          RxSparse: spi_if.ready <= ((tick % 4) == 0);
          default:  spi_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Offers one command word and waits for it to be taken; the sender runs in bursts.
  task automatic send_word(logic [7:0] data, logic first, logic [7:0] count);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd_if.valid          <= 1'b1;
    cmd_if.data_byte      <= data;
    cmd_if.first_of_frame <= first;
    cmd_if.frame_len      <= count;
    do @(posedge clk); while (!cmd_if.ready);
    burst_left--;
    if (tracker.take_command_word(data, first, count)) framed_words++;
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_frame(int count);
    int sent;
    int i;
    sent = count;
    // Now and then the frame is cut short and the next first word abandons it.
    if (count > 1 && $urandom_range(0, 9) == 0) sent = $urandom_range(1, count - 1);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3))
        send_word(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)));
    end
    send_word(8'($urandom_range(0, 255)), 1'b1, 8'(count));
    for (i = 1; i < sent; i++)
      send_word(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int r;
    int count;
    bit mid_drained;
    tracker      = new();
    burst_left   = 0;
    framed_words = 0;
    quiet_cycles = 0;
    long_hold_req = 1'b0;
    mid_drained  = 1'b0;
    cmd_if.valid          = 1'b0;
    cmd_if.data_byte      = 8'h00;
    cmd_if.first_of_frame = 1'b0;
    cmd_if.frame_len      = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    send_word(8'hA5, 1'b0, 8'd3);     // idle word without first flag is dropped
    send_word(8'h00, 1'b1, 8'd1);     // one-byte frame
    send_word(8'hFF, 1'b1, 8'd1);
    send_word(8'h5A, 1'b1, 8'd0);     // count of zero acts as one
    send_word(8'h80, 1'b1, 8'd2);
    send_word(8'h7F, 1'b0, 8'hFF);
    send_word(8'hFF, 1'b0, 8'hFF);    // dropped again after the frame closed
    send_word(8'h11, 1'b1, 8'd255);   // count of 255 clamps to 254
    send_word(8'hFF, 1'b0, 8'h00);
    send_word(8'h00, 1'b0, 8'hAA);
    send_word(8'hC3, 1'b1, 8'd254);   // abandons the open frame
    send_word(8'h3C, 1'b0, 8'h55);
    send_word(8'hFF, 1'b1, 8'd3);
    send_word(8'hFF, 1'b0, 8'h00);
    send_word(8'hFF, 1'b0, 8'h00);
    send_word(8'h01, 1'b1, 8'd128);
    send_word(8'h02, 1'b1, 8'd4);
    send_word(8'h04, 1'b0, 8'h00);
    send_word(8'h08, 1'b0, 8'h00);
    send_word(8'h10, 1'b0, 8'h00);
    drain();

    // Random part: a full-length frame first, with the receiver holding off meanwhile.
    framed_words  = 0;
    long_hold_req <= 1'b1;
    random_frame(254);
    while (framed_words < RandomTarget) begin
      r = $urandom_range(0, 99);
      if (r < 65)      count = $urandom_range(1, 6);
      else if (r < 92) count = $urandom_range(7, 24);
      else             count = $urandom_range(25, 80);
      random_frame(count);
      if (!mid_drained && framed_words > 350) begin
        mid_drained = 1'b1;
        drain();
      end
    end
    // Abandon any frame left open with a one-byte frame, so that the stream ends on a checked trailer.
    send_word(8'($urandom_range(0, 255)), 1'b1, 8'd1);
    drain();
    repeat (30) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
